### hw/rtl/line_segment_grid_binning_core_defines.svh
// ----------------------------------------------------------------------------
// line segment grid binning - assertion macros
// shared concurrent assertion helpers, clocked on clk_i and off during reset
// ----------------------------------------------------------------------------
`ifndef LINE_SEGMENT_GRID_BINNING_CORE_DEFINES_SVH
`define LINE_SEGMENT_GRID_BINNING_CORE_DEFINES_SVH

// property must hold at every edge out of reset
`define LSGB_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lsgb assertion failed");

// condition must never be seen out of reset
`define LSGB_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("lsgb forbidden condition seen");

`endif

### hw/rtl/lsgb_pkg.sv
// ----------------------------------------------------------------------------
// lsgb_pkg - line segment grid binning package
// widths, record types and the scale table shared by the binning core
// ----------------------------------------------------------------------------
package lsgb_pkg;

  localparam int CoordW     = 16;
  localparam int RelW       = CoordW + 1;
  localparam int IdxW       = 15;
  localparam int BnW        = 10;
  localparam int ColW       = 6;
  localparam int SclW       = 10;
  localparam int BlockShift = 7;
  localparam int SizeW      = SclW + BlockShift;
  localparam int BlkW       = RelW - BlockShift + 1;
  localparam int NumW       = 24;
  localparam int CellW      = 2 * ColW;
  localparam int MulAW      = 29;
  localparam int MulBW      = BlkW;
  localparam int ProdW      = MulAW + MulBW;
  localparam int XW         = ProdW + 1;
  localparam int DenW       = 29;
  localparam int QW         = 26;
  localparam int RunW       = 7;
  localparam int MaxOut     = 64;
  localparam int MaxColumns = 32;
  localparam int MaxRows    = 32;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 16;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_COLUMNS  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ROWS     = 3'd3;

  typedef enum logic [1:0] {
    KIND_SINGLE = 2'd0,
    KIND_HRUN   = 2'd1,
    KIND_VRUN   = 2'd2,
    KIND_DIAG   = 2'd3
  } kind_e;

  // effective grid setup, columns and rows already saturated
  typedef struct packed {
    logic signed [CoordW-1:0] origin_x;
    logic signed [CoordW-1:0] origin_y;
    logic [ColW-1:0]          cols;
    logic [ColW-1:0]          rows;
    logic [SclW-1:0]          scl;
  } cfg_t;

  // classified segment handed from front to back
  typedef struct packed {
    logic [IdxW-1:0]        owner;
    kind_e                  kind;
    logic signed [RelW-1:0] rsx;
    logic signed [RelW-1:0] rsy;
    logic signed [RelW-1:0] rex;
    logic signed [RelW-1:0] dx;
    logic signed [RelW-1:0] dy;
    logic signed [BlkW-1:0] bxf;
    logic signed [BlkW-1:0] byf;
    logic signed [NumW-1:0] b0;
    logic [RunW-1:0]        run_cnt;
  } desc_t;

  typedef struct packed {
    logic [BnW-1:0]  block;
    logic [IdxW-1:0] owner;
    logic            in_grid;
    logic            last;
  } res_t;

  typedef struct packed {
    logic                   start;
    logic signed [XW-1:0]   num;
    logic signed [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic signed [XW-1:0] quot;
  } div_rsp_t;

  // 81920 / (100 + rows), truncated
  function automatic logic [SclW-1:0] scale_of(input logic [ColW-1:0] rows);
    logic [SclW-1:0] s;
    unique case (rows)
      6'd0:    s = 10'd819;
      6'd1:    s = 10'd811;
      6'd2:    s = 10'd803;
      6'd3:    s = 10'd795;
      6'd4:    s = 10'd787;
      6'd5:    s = 10'd780;
      6'd6:    s = 10'd772;
      6'd7:    s = 10'd765;
      6'd8:    s = 10'd758;
      6'd9:    s = 10'd751;
      6'd10:   s = 10'd744;
      6'd11:   s = 10'd738;
      6'd12:   s = 10'd731;
      6'd13:   s = 10'd724;
      6'd14:   s = 10'd718;
      6'd15:   s = 10'd712;
      6'd16:   s = 10'd706;
      6'd17:   s = 10'd700;
      6'd18:   s = 10'd694;
      6'd19:   s = 10'd688;
      6'd20:   s = 10'd682;
      6'd21:   s = 10'd677;
      6'd22:   s = 10'd671;
      6'd23:   s = 10'd666;
      6'd24:   s = 10'd660;
      6'd25:   s = 10'd655;
      6'd26:   s = 10'd650;
      6'd27:   s = 10'd645;
      6'd28:   s = 10'd640;
      6'd29:   s = 10'd635;
      6'd30:   s = 10'd630;
      6'd31:   s = 10'd625;
      default: s = 10'd620;
    endcase
    return s;
  endfunction

endpackage

### hw/rtl/lsgb_front.sv
// ----------------------------------------------------------------------------
// lsgb_front - segment intake and classification
// finds endpoint blocks, sorts the segment into its case, queues a descriptor
// ----------------------------------------------------------------------------
module lsgb_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  output logic                               full_o,
  input  logic [lsgb_pkg::IdxW-1:0]          segment_index_i,
  input  logic signed [lsgb_pkg::CoordW-1:0] start_x_i,
  input  logic signed [lsgb_pkg::CoordW-1:0] start_y_i,
  input  logic signed [lsgb_pkg::CoordW-1:0] end_x_i,
  input  logic signed [lsgb_pkg::CoordW-1:0] end_y_i,
  input  lsgb_pkg::cfg_t                     cfg_i,
  input  logic                               desc_pop_i,
  output logic                               desc_valid_o,
  output lsgb_pkg::desc_t                    desc_o
);
  import lsgb_pkg::*;

  // block coordinate, truncated toward zero
  function automatic logic signed [BlkW-1:0] blk_of(input logic signed [RelW-1:0] v);
    logic signed [RelW-1:0] f;
    f = v >>> BlockShift;
    if (v[RelW-1] && (v[BlockShift-1:0] != '0)) begin
      f = f + RelW'(1);
    end
    return f[BlkW-1:0];
  endfunction

  // block count of a straight run, capped at the result limit
  function automatic logic [RunW-1:0] run_len(input logic signed [BlkW-1:0] a,
                                              input logic signed [BlkW-1:0] b);
    logic signed [BlkW:0] d;
    logic [BlkW:0]        mag;
    d   = {b[BlkW-1], b} - {a[BlkW-1], a};
    mag = d[BlkW] ? -d : d;
    if (mag >= (BlkW+1)'(MaxOut - 1)) begin
      return RunW'(MaxOut);
    end
    return RunW'(mag + (BlkW+1)'(1));
  endfunction

  logic signed [RelW-1:0] rsx, rsy, rex, rey, dx, dy;
  logic signed [BlkW-1:0] bxf, byf, bxt, byt;
  logic signed [NumW-1:0] cols_s, b0;
  desc_t                  desc_new;
  desc_t                  mem_q [2];
  logic                   wptr_q, rptr_q;
  logic [1:0]             cnt_q;
  logic                   do_push, do_pop;

  // coordinates relative to the grid origin
  assign rsx = RelW'(start_x_i) - RelW'(cfg_i.origin_x);
  assign rsy = RelW'(start_y_i) - RelW'(cfg_i.origin_y);
  assign rex = RelW'(end_x_i) - RelW'(cfg_i.origin_x);
  assign rey = RelW'(end_y_i) - RelW'(cfg_i.origin_y);
  assign dx  = RelW'(end_x_i) - RelW'(start_x_i);
  assign dy  = RelW'(end_y_i) - RelW'(start_y_i);

  assign bxf = blk_of(rsx);
  assign byf = blk_of(rsy);
  assign bxt = blk_of(rex);
  assign byt = blk_of(rey);

  // first block number
  assign cols_s = NumW'(cfg_i.cols);
  assign b0     = NumW'(bxf) + cols_s * NumW'(byf);

  // classify
  always_comb begin
    desc_new.owner = segment_index_i;
    desc_new.rsx   = rsx;
    desc_new.rsy   = rsy;
    desc_new.rex   = rex;
    desc_new.dx    = dx;
    desc_new.dy    = dy;
    desc_new.bxf   = bxf;
    desc_new.byf   = byf;
    desc_new.b0    = b0;
    priority if ((bxf == bxt) && (byf == byt)) begin
      desc_new.kind    = KIND_SINGLE;
      desc_new.run_cnt = RunW'(1);
    end else if (byf == byt) begin
      desc_new.kind    = KIND_HRUN;
      desc_new.run_cnt = run_len(bxf, bxt);
    end else if (bxf == bxt) begin
      desc_new.kind    = KIND_VRUN;
      desc_new.run_cnt = run_len(byf, byt);
    end else begin
      desc_new.kind    = KIND_DIAG;
      desc_new.run_cnt = RunW'(1);
    end
  end

  // two-entry descriptor queue
  assign full_o       = (cnt_q == 2'd2);
  assign desc_valid_o = (cnt_q != 2'd0);
  assign desc_o       = mem_q[rptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = desc_pop_i && desc_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_q <= !wptr_q;
      end
      if (do_pop) begin
        rptr_q <= !rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= desc_new;
    end
  end

endmodule

### hw/rtl/lsgb_div.sv
// ----------------------------------------------------------------------------
// lsgb_div - shared signed divider
// restoring division, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module lsgb_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lsgb_pkg::div_req_t  req_i,
  output lsgb_pkg::div_rsp_t  rsp_o
);
  import lsgb_pkg::*;

  localparam int CntW = $clog2(XW + 1);

  logic                busy_q, done_q, neg_q;
  logic [CntW-1:0]     cnt_q;
  logic [DenW-1:0]     rem_q, dmag_q;
  logic [XW-1:0]       quo_q;
  logic [DenW:0]       rem_sh;
  logic                ge;

  // one restoring step
  assign rem_sh = {rem_q, quo_q[XW-1]};
  assign ge     = (rem_sh >= {1'b0, dmag_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(XW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q  <= req_i.num[XW-1] ? -req_i.num : req_i.num;
      dmag_q <= req_i.den[DenW-1] ? -req_i.den : req_i.den;
      rem_q  <= '0;
      neg_q  <= req_i.num[XW-1] ^ req_i.den[DenW-1];
    end else if (busy_q) begin
      rem_q <= ge ? DenW'(rem_sh - {1'b0, dmag_q}) : DenW'(rem_sh);
      quo_q <= {quo_q[XW-2:0], ge};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

### hw/rtl/lsgb_back.sv
// ----------------------------------------------------------------------------
// lsgb_back - block walk sequencer
// emits single blocks and straight runs directly; sets up and walks diagonal segments row by row
// ----------------------------------------------------------------------------
`include "line_segment_grid_binning_core_defines.svh"

module lsgb_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lsgb_pkg::cfg_t     cfg_i,
  input  logic               desc_valid_i,
  input  lsgb_pkg::desc_t    desc_i,
  output logic               desc_pop_o,
  output lsgb_pkg::div_req_t div_req_o,
  input  lsgb_pkg::div_rsp_t div_rsp_i,
  input  logic               out_full_i,
  output logic               out_push_o,
  output lsgb_pkg::res_t     out_rec_o
);
  import lsgb_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_RUN  = 16'h0002,
    S_XF   = 16'h0004,
    S_XT   = 16'h0008,
    S_YF   = 16'h0010,
    S_BS   = 16'h0020,
    S_NUM  = 16'h0040,
    S_MDY  = 16'h0080,
    S_WM   = 16'h0100,
    S_NM   = 16'h0200,
    S_WX   = 16'h0400,
    S_SS   = 16'h0800,
    S_WS   = 16'h1000,
    S_ROW  = 16'h2000,
    S_WR   = 16'h4000,
    S_EMIT = 16'h8000
  } state_e;

  state_e                  state_q, state_d;
  desc_t                   desc_q, desc_d;
  logic signed [NumW-1:0]  b_q, b_d;
  logic [RunW-1:0]         out_cnt_q, out_cnt_d;
  logic [RunW-1:0]         run_q, run_d;
  logic signed [XW-1:0]    xf_q, xf_d, xt_q, xt_d, xst_q, xst_d;
  logic signed [MulAW-1:0] yf_q, yf_d, tmp_q, tmp_d;
  logic signed [DenW-1:0]  m_q, m_d, step_q, step_d;
  logic signed [QW-1:0]    bxs_q, bxs_d;
  div_req_t                dreq_q, dreq_d;

  logic [SizeW-1:0]        size;
  logic [CellW-1:0]        cells;
  logic signed [MulAW-1:0] mul_a, adj;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod;
  logic signed [NumW-1:0]  cols_s, p_cols, p_run, xd_val;
  logic signed [XW-1:0]    xn;
  logic signed [DenW-1:0]  q_den;
  logic signed [QW-1:0]    q_row;
  logic signed [QW:0]      dq;
  logic [QW:0]             dq_mag;
  logic                    xd_neg, yd_neg, cont, last, emit_st;

  assign size   = {cfg_i.scl, {BlockShift{1'b0}}};
  assign cells  = CellW'(cfg_i.cols) * CellW'(cfg_i.rows);
  assign xd_neg = desc_q.dx[RelW-1];
  assign yd_neg = desc_q.dy[RelW-1];
  assign cols_s = NumW'(cfg_i.cols);
  assign p_cols = yd_neg ? -cols_s : cols_s;
  assign xd_val = xd_neg ? -NumW'(1) : NumW'(1);
  assign p_run  = (desc_q.kind == KIND_HRUN) ? xd_val : p_cols;

  // shared multiplier, operands picked by the sequencer
  always_comb begin
    unique case (state_q)
      S_XF: begin
        mul_a = MulAW'(desc_q.rsx);
        mul_b = MulBW'(cfg_i.scl);
      end
      S_XT: begin
        mul_a = MulAW'(desc_q.rex);
        mul_b = MulBW'(cfg_i.scl);
      end
      S_YF: begin
        mul_a = MulAW'(desc_q.rsy);
        mul_b = MulBW'(cfg_i.scl);
      end
      S_BS: begin
        mul_a = MulAW'(size);
        mul_b = desc_q.byf;
      end
      S_MDY: begin
        mul_a = MulAW'(desc_q.dy);
        mul_b = MulBW'(cfg_i.scl);
      end
      S_NM: begin
        mul_a = tmp_q;
        mul_b = MulBW'(cfg_i.scl);
      end
      S_SS: begin
        mul_a = MulAW'(size);
        mul_b = MulBW'(cfg_i.scl);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // row and walk helpers
  assign adj    = yd_neg ? -MulAW'(1) : MulAW'(size);
  assign q_den  = DenW'(div_rsp_i.quot);
  assign q_row  = QW'(div_rsp_i.quot);
  assign dq     = {q_row[QW-1], q_row} - {bxs_q[QW-1], bxs_q};
  assign dq_mag = dq[QW] ? -dq : dq;
  assign cont   = xd_neg ? (xst_q > xt_q) : (xst_q < xt_q);
  assign xn     = xst_q + XW'(step_q);

  // result record
  assign emit_st = (state_q == S_RUN) || (state_q == S_EMIT);
  assign out_push_o = emit_st && !out_full_i;
  always_comb begin
    if (state_q == S_RUN) begin
      last = (run_q == RunW'(1)) || (out_cnt_q == RunW'(MaxOut - 1));
    end else begin
      last = ((run_q == '0) && !cont) || (out_cnt_q == RunW'(MaxOut - 1));
    end
  end
  assign out_rec_o.block   = b_q[BnW-1:0];
  assign out_rec_o.owner   = desc_q.owner;
  assign out_rec_o.in_grid = !b_q[NumW-1] && (b_q[NumW-2:0] < (NumW-1)'(cells));
  assign out_rec_o.last    = last;

  assign desc_pop_o = (state_q == S_IDLE) && desc_valid_i;
  assign div_req_o  = dreq_q;

  // sequencer
  always_comb begin
    state_d      = state_q;
    desc_d       = desc_q;
    b_d          = b_q;
    out_cnt_d    = out_cnt_q;
    run_d        = run_q;
    xf_d         = xf_q;
    xt_d         = xt_q;
    xst_d        = xst_q;
    yf_d         = yf_q;
    tmp_d        = tmp_q;
    m_d          = m_q;
    step_d       = step_q;
    bxs_d        = bxs_q;
    dreq_d       = dreq_q;
    dreq_d.start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (desc_valid_i) begin
          desc_d    = desc_i;
          b_d       = desc_i.b0;
          out_cnt_d = '0;
          run_d     = desc_i.run_cnt;
          bxs_d     = QW'(desc_i.bxf);
          state_d   = (desc_i.kind == KIND_DIAG) ? S_XF : S_RUN;
        end
      end
      S_RUN: begin
        if (!out_full_i) begin
          out_cnt_d = out_cnt_q + RunW'(1);
          run_d     = run_q - RunW'(1);
          b_d       = b_q + p_run;
          if (last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_XF: begin
        xf_d    = XW'(prod);
        state_d = S_XT;
      end
      S_XT: begin
        xt_d    = XW'(prod);
        state_d = S_YF;
      end
      S_YF: begin
        yf_d    = MulAW'(prod);
        state_d = S_BS;
      end
      S_BS: begin
        tmp_d   = MulAW'(prod);
        state_d = S_NUM;
      end
      S_NUM: begin
        tmp_d   = tmp_q + adj - yf_q;
        state_d = S_MDY;
      end
      S_MDY: begin
        dreq_d.start = 1'b1;
        dreq_d.num   = XW'(prod);
        dreq_d.den   = DenW'(desc_q.dx);
        state_d      = S_WM;
      end
      S_WM: begin
        if (div_rsp_i.done) begin
          // slope that truncates to zero is forced to one unit
          if (div_rsp_i.quot == '0) begin
            m_d = (xd_neg ^ yd_neg) ? -DenW'(1) : DenW'(1);
          end else begin
            m_d = q_den;
          end
          state_d = S_NM;
        end
      end
      S_NM: begin
        dreq_d.start = 1'b1;
        dreq_d.num   = XW'(prod);
        dreq_d.den   = m_q;
        state_d      = S_WX;
      end
      S_WX: begin
        if (div_rsp_i.done) begin
          xst_d   = xf_q + div_rsp_i.quot;
          state_d = S_SS;
        end
      end
      S_SS: begin
        dreq_d.start = 1'b1;
        dreq_d.num   = XW'(prod);
        dreq_d.den   = m_q;
        state_d      = S_WS;
      end
      S_WS: begin
        if (div_rsp_i.done) begin
          step_d  = yd_neg ? -q_den : q_den;
          state_d = S_ROW;
        end
      end
      S_ROW: begin
        dreq_d.start = 1'b1;
        dreq_d.num   = xst_q;
        dreq_d.den   = DenW'(size);
        state_d      = S_WR;
      end
      S_WR: begin
        if (div_rsp_i.done) begin
          run_d   = (dq_mag > (QW+1)'(MaxOut - 1)) ? RunW'(MaxOut - 1) : RunW'(dq_mag);
          bxs_d   = q_row;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_full_i) begin
          out_cnt_d = out_cnt_q + RunW'(1);
          if (last) begin
            state_d = S_IDLE;
          end else if (run_q == '0) begin
            // row done: step to the next row and advance the crossing point
            b_d = b_q + p_cols;
            if (xd_neg ? (xn < xt_q) : (xn > xt_q)) begin
              xst_d = xt_q;
            end else begin
              xst_d = xn;
            end
            state_d = S_ROW;
          end else begin
            b_d   = b_q + xd_val;
            run_d = run_q - RunW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      dreq_q  <= '0;
    end else begin
      state_q <= state_d;
      dreq_q  <= dreq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q      <= desc_d;
    b_q         <= b_d;
    out_cnt_q   <= out_cnt_d;
    run_q       <= run_d;
    xf_q        <= xf_d;
    xt_q        <= xt_d;
    xst_q       <= xst_d;
    yf_q        <= yf_d;
    tmp_q       <= tmp_d;
    m_q         <= m_d;
    step_q      <= step_d;
    bxs_q       <= bxs_d;
  end

  // checks
  `LSGB_NEVER(a_push_when_full, out_push_o && out_full_i)
  `LSGB_NEVER(a_div_start_busy, dreq_q.start && div_rsp_i.busy)
  `LSGB_ASSERT(a_last_ends_item, (out_push_o && last) |=> (state_q == S_IDLE))
  `LSGB_NEVER(a_result_cap, emit_st && (out_cnt_q >= RunW'(MaxOut)))

endmodule

### hw/rtl/line_segment_grid_binning_core.sv
// A segment in one block or a straight run gives one block per cycle while the
// result queue is not full. A diagonal segment runs setup multiplies and three
// divisions, then one division on the shared divider per grid row before the
// blocks of that row. Items are worked one at a time; a 2-entry input queue
// and a 2-entry result queue decouple both sides. Reset is asynchronous, active
// low: queues empty, origin 0, 32 columns and 32 rows.
// ----------------------------------------------------------------------------
// line_segment_grid_binning_core - line segment grid binning top level
// configuration registers, front classifier, walk sequencer, divider, result queue
// ----------------------------------------------------------------------------
module line_segment_grid_binning_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lsgb_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [lsgb_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                 push,
  output logic                                 full,
  input  logic [lsgb_pkg::IdxW-1:0]            segment_index_i,
  input  logic signed [lsgb_pkg::CoordW-1:0]   start_x_i,
  input  logic signed [lsgb_pkg::CoordW-1:0]   start_y_i,
  input  logic signed [lsgb_pkg::CoordW-1:0]   end_x_i,
  input  logic signed [lsgb_pkg::CoordW-1:0]   end_y_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [lsgb_pkg::BnW-1:0]             block_number_o,
  output logic [lsgb_pkg::IdxW-1:0]            owner_index_o,
  output logic                                 in_grid_o,
  output logic                                 last_block_o
);
  import lsgb_pkg::*;

  logic signed [CoordW-1:0] origin_x_q, origin_y_q;
  logic [ColW-1:0]          cols_q, rows_q, cols_sat, rows_sat;
  cfg_t                     cfg;
  logic                     desc_valid, desc_pop, out_push;
  desc_t                    desc;
  div_req_t                 dreq;
  div_rsp_t                 drsp;
  res_t                     out_rec;
  res_t                     res_q [2];
  logic                     wptr_q, rptr_q;
  logic [1:0]               cnt_q;
  logic                     res_full;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      cols_q     <= ColW'(MaxColumns);
      rows_q     <= ColW'(MaxRows);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ORIGIN_X: origin_x_q <= cfg_data_i;
        CFG_ORIGIN_Y: origin_y_q <= cfg_data_i;
        CFG_COLUMNS:  cols_q     <= cfg_data_i[ColW-1:0];
        CFG_ROWS:     rows_q     <= cfg_data_i[ColW-1:0];
        default: ;
      endcase
    end
  end

  // saturated grid size and scale
  assign cols_sat     = (cols_q > ColW'(MaxColumns)) ? ColW'(MaxColumns) : cols_q;
  assign rows_sat     = (rows_q > ColW'(MaxRows)) ? ColW'(MaxRows) : rows_q;
  assign cfg.origin_x = origin_x_q;
  assign cfg.origin_y = origin_y_q;
  assign cfg.cols     = cols_sat;
  assign cfg.rows     = rows_sat;
  assign cfg.scl      = scale_of(rows_sat);

  lsgb_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_o          (full),
    .segment_index_i (segment_index_i),
    .start_x_i       (start_x_i),
    .start_y_i       (start_y_i),
    .end_x_i         (end_x_i),
    .end_y_i         (end_y_i),
    .cfg_i           (cfg),
    .desc_pop_i      (desc_pop),
    .desc_valid_o    (desc_valid),
    .desc_o          (desc)
  );

  lsgb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  lsgb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .desc_valid_i (desc_valid),
    .desc_i       (desc),
    .desc_pop_o   (desc_pop),
    .div_req_o    (dreq),
    .div_rsp_i    (drsp),
    .out_full_i   (res_full),
    .out_push_o   (out_push),
    .out_rec_o    (out_rec)
  );

  // two-entry result queue
  assign res_full = (cnt_q == 2'd2);
  assign empty    = (cnt_q == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (out_push) begin
        wptr_q <= !wptr_q;
      end
      if (pop && !empty) begin
        rptr_q <= !rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, out_push} - {1'b0, pop && !empty};
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      res_q[wptr_q] <= out_rec;
    end
  end

  assign block_number_o = res_q[rptr_q].block;
  assign owner_index_o  = res_q[rptr_q].owner;
  assign in_grid_o      = res_q[rptr_q].in_grid;
  assign last_block_o   = res_q[rptr_q].last;

endmodule
